### rtl/plr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the polyline table reducer.
// No dependencies; used by polyline_table_reducer_top only.
`default_nettype none

package plr_pkg;

   typedef logic [1:0] csr_index_type;

   localparam csr_index_type CSR_TOLERANCE = 2'd0;
   localparam csr_index_type CSR_CHANNELS  = 2'd1;

   localparam logic [1:0] MAX_CHANNELS = 2'd3;

   localparam logic [30:0] TOLERANCE_RESET = 31'd65536;
   localparam logic [1:0]  CHANNELS_RESET  = 2'd3;

   typedef struct packed {
      logic signed [31:0] level;
      logic signed [31:0] value_a;
      logic signed [31:0] value_b;
      logic signed [31:0] value_c;
   } point_type;

   localparam int POINT_WIDTH = $bits(point_type);

   typedef struct packed {
      point_type pt;
      logic      end_of_table;
      logic      forced_keep;
   } result_type;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_LIM    = 8'b0000_0010,
      S_READ   = 8'b0000_0100,
      S_MUL    = 8'b0000_1000,
      S_CMP    = 8'b0001_0000,
      S_DECIDE = 8'b0010_0000,
      S_KEEP   = 8'b0100_0000,
      S_UPD    = 8'b1000_0000
   } state_type;

endpackage

`default_nettype wire

### rtl/polyline_table_reducer_top.sv
`timescale 1ns / 1ps
// Top level of the polyline table reducer: control sequencer, run buffer RAM,
// deviation unit and result register. Uses plr_pkg, plr_ram, plr_dev.
`default_nettype none

// Drops calibration table points that lie within tolerance of the line from
// the last kept point (anchor) to the newest point. The intermediate points
// of the current run live in a RUN_DEPTH-entry RAM; each new point rereads
// the run one entry at a time through a single pair of multipliers, one
// channel per pass. Untested points go from S_IDLE to S_DECIDE; a tested
// point goes through S_LIM, then S_READ per buffered run point and S_MUL and
// S_CMP per channel until one fails, then S_DECIDE; a kept point takes S_KEEP;
// all end in S_UPD. req_stall stays high while a point is in work; results go
// out through one output register, so up to two results per point leave in
// turn. The first point after reset or after a final point starts a new table.

module polyline_table_reducer_top #(
   parameter int RUN_DEPTH = 256
) (
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire logic signed [31:0]     req_level,
   input  wire logic signed [31:0]     req_value_a,
   input  wire logic signed [31:0]     req_value_b,
   input  wire logic signed [31:0]     req_value_c,
   input  wire logic                   req_final_point,

   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      logic signed [31:0]     rsp_kept_level,
   output      logic signed [31:0]     rsp_kept_a,
   output      logic signed [31:0]     rsp_kept_b,
   output      logic signed [31:0]     rsp_kept_c,
   output      logic                   rsp_end_of_table,
   output      logic                   rsp_forced_keep,

   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire plr_pkg::csr_index_type csr_index,
   input  wire logic [30:0]            csr_wdata
);

   import plr_pkg::*;

   localparam int AW = $clog2(RUN_DEPTH);
   localparam int CW = $clog2(RUN_DEPTH + 1);

   state_type          state_ff, state_in;
   logic [30:0]        tol_ff, tol_in;
   logic [1:0]         chan_ff, chan_in;
   point_type          anchor_ff, anchor_in;
   point_type          last_ff, last_in;
   point_type          p_ff, p_in;
   logic               fin_ff, fin_in;
   logic               first_ff, first_in;
   logic               lin_ff, lin_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               have_ff, have_in;
   logic [AW-1:0]      j_ff, j_in;
   logic [1:0]         c_ff, c_in;
   logic [1:0]         nch_ff, nch_in;
   logic signed [32:0] dx_ff, dx_in;
   logic [32:0]        dxmag_ff, dxmag_in;
   logic signed [32:0] dy_ff [3];
   logic signed [32:0] dy_in [3];
   logic [63:0]        lim_ff, lim_in;
   result_type         rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               accept;
   logic               slot_free;
   logic               rsp_load;
   logic               need_keep;
   logic [1:0]         nch_cur;

   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic               ram_re;
   point_type          ram_rdata;
   logic [POINT_WIDTH-1:0] ram_rdata_raw;

   logic signed [31:0] rd_val;
   logic signed [31:0] an_val;
   logic signed [32:0] dj;
   logic signed [32:0] dyj;
   logic               pass;

   function automatic logic signed [31:0] chan_value(point_type pt, logic [1:0] sel);
      logic signed [31:0] v;
      case (sel)
         2'd0:    v = pt.value_a;
         2'd1:    v = pt.value_b;
         default: v = pt.value_c;
      endcase
      return v;
   endfunction

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      if (chan_ff == 2'd0) begin
         nch_cur = 2'd1;
      end else if (chan_ff > MAX_CHANNELS) begin
         nch_cur = MAX_CHANNELS;
      end else begin
         nch_cur = chan_ff;
      end
   end

   assign need_keep = !first_ff && (count_ff != '0) &&
                      (!lin_ff || (count_ff == CW'(RUN_DEPTH)));

   assign ram_rdata = point_type'(ram_rdata_raw);
   assign rd_val    = chan_value(ram_rdata, c_ff);
   assign an_val    = chan_value(anchor_ff, c_ff);
   assign dj        = {ram_rdata.level[31], ram_rdata.level} -
                      {anchor_ff.level[31], anchor_ff.level};
   assign dyj       = {rd_val[31], rd_val} - {an_val[31], an_val};

   // reads happen only in the test states, writes only in S_UPD
   assign ram_re    = (state_ff == S_READ);
   assign ram_we    = (state_ff == S_UPD) && !first_ff && (!fin_ff || slot_free);
   assign ram_waddr = (count_ff != '0 && lin_ff && count_ff < CW'(RUN_DEPTH)) ?
                      count_ff[AW-1:0] : '0;

   plr_ram #(
      .WIDTH (POINT_WIDTH),
      .DEPTH (RUN_DEPTH)
   ) u_run_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (p_ff),
      .re    (ram_re),
      .raddr (j_ff),
      .rdata (ram_rdata_raw)
   );

   plr_dev u_dev (
      .clock  (clock),
      .mul_en (state_ff == S_MUL),
      .dy     (dy_ff[c_ff]),
      .dj     (dj),
      .dyj    (dyj),
      .dx     (dx_ff),
      .lim    (lim_ff),
      .pass   (pass)
   );

   always_comb begin
      state_in     = state_ff;
      tol_in       = tol_ff;
      chan_in      = chan_ff;
      anchor_in    = anchor_ff;
      last_in      = last_ff;
      p_in         = p_ff;
      fin_in       = fin_ff;
      first_in     = first_ff;
      lin_in       = lin_ff;
      count_in     = count_ff;
      have_in      = have_ff;
      j_in         = j_ff;
      c_in         = c_ff;
      nch_in       = nch_ff;
      dx_in        = dx_ff;
      dxmag_in     = dxmag_ff;
      dy_in        = dy_ff;
      lim_in       = lim_ff;
      rsp_in       = rsp_ff;
      rsp_load     = 1'b0;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TOLERANCE: tol_in  = csr_wdata;
            CSR_CHANNELS:  chan_in = csr_wdata[1:0];
            default:       ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               p_in     = '{req_level, req_value_a, req_value_b, req_value_c};
               fin_in   = req_final_point;
               first_in = !have_ff;
               nch_in   = nch_cur;
               dx_in    = {req_level[31], req_level} -
                          {anchor_ff.level[31], anchor_ff.level};
               dxmag_in = dx_in[32] ? 33'(-dx_in) : 33'(dx_in);
               dy_in[0] = {req_value_a[31], req_value_a} -
                          {anchor_ff.value_a[31], anchor_ff.value_a};
               dy_in[1] = {req_value_b[31], req_value_b} -
                          {anchor_ff.value_b[31], anchor_ff.value_b};
               dy_in[2] = {req_value_c[31], req_value_c} -
                          {anchor_ff.value_c[31], anchor_ff.value_c};
               j_in     = '0;
               c_in     = 2'd0;
               if (have_ff && count_ff != '0 && dx_in != '0) begin
                  state_in = S_LIM;
               end else begin
                  lin_in   = 1'b1;
                  state_in = S_DECIDE;
               end
            end
         end
         S_LIM: begin
            lim_in   = 64'(tol_ff) * 64'(dxmag_ff);
            state_in = S_READ;
         end
         S_READ: begin
            state_in = S_MUL;
         end
         S_MUL: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            if (!pass) begin
               lin_in   = 1'b0;
               state_in = S_DECIDE;
            end else if ((c_ff + 2'd1) < nch_ff) begin
               c_in     = c_ff + 2'd1;
               state_in = S_MUL;
            end else if ((CW'(j_ff) + CW'(1)) < count_ff) begin
               j_in     = j_ff + AW'(1);
               c_in     = 2'd0;
               state_in = S_READ;
            end else begin
               lin_in   = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = need_keep ? S_KEEP : S_UPD;
         end
         S_KEEP: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               rsp_in   = '{last_ff, 1'b0, lin_ff};
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            if (!(first_ff || fin_ff) || slot_free) begin
               state_in = S_IDLE;
               if (first_ff || fin_ff) begin
                  rsp_load = 1'b1;
                  rsp_in   = '{p_ff, fin_ff, 1'b0};
               end
               if (first_ff) begin
                  anchor_in = p_ff;
                  count_in  = '0;
                  have_in   = !fin_ff;
               end else begin
                  last_in = p_ff;
                  if (count_ff == '0) begin
                     count_in = CW'(1);
                  end else if (lin_ff && count_ff < CW'(RUN_DEPTH)) begin
                     count_in = count_ff + CW'(1);
                  end else begin
                     anchor_in = last_ff;
                     count_in  = CW'(1);
                  end
                  if (fin_ff) begin
                     count_in = '0;
                     have_in  = 1'b0;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tol_ff       <= TOLERANCE_RESET;
         chan_ff      <= CHANNELS_RESET;
         anchor_ff    <= '0;
         count_ff     <= '0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tol_ff       <= tol_in;
         chan_ff      <= chan_in;
         anchor_ff    <= anchor_in;
         count_ff     <= count_in;
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff  <= last_in;
      p_ff     <= p_in;
      fin_ff   <= fin_in;
      first_ff <= first_in;
      lin_ff   <= lin_in;
      j_ff     <= j_in;
      c_ff     <= c_in;
      nch_ff   <= nch_in;
      dx_ff    <= dx_in;
      dxmag_ff <= dxmag_in;
      dy_ff    <= dy_in;
      lim_ff   <= lim_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kept_level   = rsp_ff.pt.level;
   assign rsp_kept_a       = rsp_ff.pt.value_a;
   assign rsp_kept_b       = rsp_ff.pt.value_b;
   assign rsp_kept_c       = rsp_ff.pt.value_c;
   assign rsp_end_of_table = rsp_ff.end_of_table;
   assign rsp_forced_keep  = rsp_ff.forced_keep;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(RUN_DEPTH))
      else $error("run count beyond buffer depth");

   a_no_anchor_empty: assert property (@(posedge clock) disable iff (reset)
      !have_ff |-> (count_ff == '0))
      else $error("run points held without an anchor");

   a_ram_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("run buffer read and write in the same cycle");

   a_end_clears_anchor: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_in.end_of_table) |=> !have_ff)
      else $error("anchor kept after end of table");

endmodule

`default_nettype wire

### rtl/plr_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module plr_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### rtl/plr_dev.sv
`timescale 1ns / 1ps
// Deviation unit: two registered 33x33 signed products, then the
// cross-multiplied tolerance test against the registered limit. No dependencies.
`default_nettype none

module plr_dev (
   input  wire logic               clock,
   input  wire logic               mul_en,
   input  wire logic signed [32:0] dy,
   input  wire logic signed [32:0] dj,
   input  wire logic signed [32:0] dyj,
   input  wire logic signed [32:0] dx,
   input  wire logic [63:0]        lim,
   output      logic               pass
);

   logic signed [65:0] prod_a_ff, prod_a_in;
   logic signed [65:0] prod_b_ff, prod_b_in;
   logic signed [66:0] dev;
   logic signed [66:0] lim_pos;
   logic signed [66:0] lim_neg;

   assign prod_a_in = dy * dj;
   assign prod_b_in = dyj * dx;

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_a_ff <= prod_a_in;
         prod_b_ff <= prod_b_in;
      end
   end

   assign dev     = {prod_a_ff[65], prod_a_ff} - {prod_b_ff[65], prod_b_ff};
   assign lim_pos = {3'b000, lim};
   assign lim_neg = -lim_pos;
   assign pass    = (dev < lim_pos) && (dev > lim_neg);

endmodule

`default_nettype wire
